// ===== design/plsa_pkg.sv =====
// plsa_pkg: shared types and constants of the plsa sparse m-step block
// no dependencies
package plsa_pkg;

  localparam int unsigned WordW  = 12;
  localparam int unsigned DocW   = 12;
  localparam int unsigned TopicW = 6;
  localparam int unsigned AccW   = 64;
  localparam int unsigned ProbW  = 17;
  localparam int unsigned RespW  = 17;
  localparam int unsigned CountW = 32;
  localparam int unsigned IdxW   = WordW + TopicW;
  localparam int unsigned FracSteps = 16;
  localparam int unsigned StepW  = 5;
  localparam logic [RespW-1:0] RespOne = RespW'(65536);
  localparam logic [ProbW-1:0] ProbOne = ProbW'(65536);

  typedef enum logic [1:0] {
    OP_ACC      = 2'd0,
    OP_RD_WORD  = 2'd1,
    OP_RD_TOPIC = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DIV_INIT,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [WordW-1:0]  word;
    logic [DocW-1:0]   doc;
    logic [TopicW-1:0] topic;
    logic [CountW-1:0] count;
    logic [RespW-1:0]  resp;
  } req_t;

  typedef struct packed {
    logic [ProbW-1:0] prob;
    logic             zero_sum;
  } rsp_t;

  // saturating 64-bit add
  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccW] ? {AccW{1'b1}} : s[AccW-1:0];
  endfunction

endpackage

// ===== design/plsa_if.sv =====
// plsa_req_if / plsa_rsp_if: valid-ready channels of the plsa block
// depends on plsa_pkg
interface plsa_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [plsa_pkg::WordW-1:0]  word;
  logic [plsa_pkg::DocW-1:0]   doc;
  logic [plsa_pkg::TopicW-1:0] topic;
  logic [plsa_pkg::CountW-1:0] count;
  logic [plsa_pkg::RespW-1:0]  resp;
  modport source (output valid, op, word, doc, topic, count, resp, input ready);
  modport sink   (input valid, op, word, doc, topic, count, resp, output ready);
endinterface

interface plsa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [plsa_pkg::ProbW-1:0] prob;
  logic                       zero_sum;
  modport source (output valid, prob, zero_sum, input ready);
  modport sink   (input valid, prob, zero_sum, output ready);
endinterface

// ===== design/plsa_sparse_m_step.sv =====
// plsa_sparse_m_step: m-step accumulators and normalized reads of sparse plsa
// depends on plsa_pkg and plsa_if
//
//   channel | dir | carries
//   req_i   | in  | op, word, doc, topic, count, resp
//   rsp_o   | out | prob, zero_sum (one per read request)
//
// accumulate: capture and memory read, multiply, saturating write back
// read: capture and memory read, operand latch, divider setup, 16 restoring divide
//   steps, response; the steps are skipped when the sum is zero or the entry reaches it
// clear and reset: a clearing pass over 262144 entries, one entry per memory per cycle
// one request is in flight at a time; a pending response blocks new requests
module plsa_sparse_m_step (
  input  logic clk_i,
  input  logic rst_ni,
  plsa_req_if.sink   req_i,
  plsa_rsp_if.source rsp_o
);
  import plsa_pkg::*;

  localparam int unsigned Depth = 2 ** IdxW;

  state_e state_q, state_d;
  req_t   req_q;
  logic [IdxW-1:0] clr_cnt_q;
  logic [AccW-1:0] prod_q;
  logic [AccW-1:0] wt_rd_q, td_rd_q, tt_rd_q, dt_rd_q;
  logic [AccW-1:0] num_q, den_q;
  logic [ProbW-1:0] quo_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  rsp_t             out_q;

  logic [AccW-1:0] wt_mem [Depth];
  logic [AccW-1:0] td_mem [Depth];
  logic [AccW-1:0] tt_mem [2**TopicW];
  logic [AccW-1:0] dt_mem [2**DocW];

  logic            mem_we;
  logic [IdxW-1:0] wt_idx, td_idx;
  logic [TopicW-1:0] tt_idx;
  logic [DocW-1:0]   dt_idx;
  logic [AccW-1:0] wt_wd, td_wd, tt_wd, dt_wd;
  logic            accept;
  logic [AccW:0]   div_sh;
  logic [AccW-1:0] sel_acc, sel_sum;
  logic [RespW-1:0]        resp_sat;
  logic [CountW+RespW-1:0] prod_w;

  assign accept = req_i.valid & req_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == {IdxW{1'b1}}) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_d = (op_e'(req_i.op) == OP_CLEAR) ? ST_CLEAR : ST_READ;
        end
      end
      ST_READ:     state_d = (op_e'(req_q.op) == OP_ACC) ? ST_WRITE : ST_DIV_INIT;
      ST_WRITE:    state_d = ST_IDLE;
      ST_DIV_INIT: state_d = (den_q == '0 || num_q >= den_q) ? ST_IDLE : ST_DIV;
      ST_DIV:      if (step_q == StepW'(FracSteps - 1)) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    req_i.ready = (state_q == ST_IDLE) && !out_valid_q;
    mem_we = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
    if (state_q == ST_CLEAR) begin
      wt_idx = clr_cnt_q;
      td_idx = clr_cnt_q;
      tt_idx = clr_cnt_q[TopicW-1:0];
      dt_idx = clr_cnt_q[DocW-1:0];
      wt_wd = '0;
      td_wd = '0;
      tt_wd = '0;
      dt_wd = '0;
    end else begin
      // read straight from the incoming request while idle
      if (state_q == ST_IDLE) begin
        wt_idx = {req_i.word, req_i.topic};
        td_idx = {req_i.topic, req_i.doc};
        tt_idx = req_i.topic;
        dt_idx = req_i.doc;
      end else begin
        wt_idx = {req_q.word, req_q.topic};
        td_idx = {req_q.topic, req_q.doc};
        tt_idx = req_q.topic;
        dt_idx = req_q.doc;
      end
      wt_wd = sat_add(wt_rd_q, prod_q);
      td_wd = sat_add(td_rd_q, prod_q);
      tt_wd = sat_add(tt_rd_q, prod_q);
      dt_wd = sat_add(dt_rd_q, prod_q);
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.prob     = out_q.prob;
  assign rsp_o.zero_sum = out_q.zero_sum;

  // accumulator memories, one read and one write port each
  always_ff @(posedge clk_i) begin
    if (mem_we) wt_mem[wt_idx] <= wt_wd;
    wt_rd_q <= wt_mem[wt_idx];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) td_mem[td_idx] <= td_wd;
    td_rd_q <= td_mem[td_idx];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tt_mem[tt_idx] <= tt_wd;
    tt_rd_q <= tt_mem[tt_idx];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) dt_mem[dt_idx] <= dt_wd;
    dt_rd_q <= dt_mem[dt_idx];
  end

  // operand select and divide step
  assign sel_acc = (op_e'(req_q.op) == OP_RD_WORD) ? wt_rd_q : td_rd_q;
  assign sel_sum = (op_e'(req_q.op) == OP_RD_WORD) ? tt_rd_q : dt_rd_q;
  assign div_sh  = {num_q, 1'b0};

  // saturated responsibility and full-width product
  assign resp_sat = (req_q.resp > RespOne) ? RespOne : req_q.resp;
  assign prod_w   = (CountW+RespW)'(req_q.count) * (CountW+RespW)'(resp_sat);

  // request capture, product and divider datapath
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i.op == OP_CLEAR ? req_q : '{
      op: req_i.op, word: req_i.word, doc: req_i.doc, topic: req_i.topic,
      count: req_i.count, resp: req_i.resp};
    if (state_q == ST_READ) begin
      prod_q <= AccW'(prod_w);
      num_q  <= sel_acc;
      den_q  <= sel_sum;
    end else if (state_q == ST_DIV) begin
      if (div_sh >= {1'b0, den_q}) begin
        num_q <= AccW'(div_sh - {1'b0, den_q});
        quo_q <= {quo_q[ProbW-2:0], 1'b1};
      end else begin
        num_q <= div_sh[AccW-1:0];
        quo_q <= {quo_q[ProbW-2:0], 1'b0};
      end
    end else if (state_q == ST_DIV_INIT) begin
      quo_q <= '0;
    end
    if (state_q == ST_DIV_INIT) begin
      if (den_q == '0) begin
        out_q <= '{prob: '0, zero_sum: 1'b1};
      end else if (num_q >= den_q) begin
        out_q <= '{prob: ProbOne, zero_sum: 1'b0};
      end
    end else if (state_q == ST_DIV && step_q == StepW'(FracSteps - 1)) begin
      out_q <= '{prob: (div_sh >= {1'b0, den_q}) ? {quo_q[ProbW-2:0], 1'b1}
                                                 : {quo_q[ProbW-2:0], 1'b0},
                 zero_sum: 1'b0};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      else clr_cnt_q <= '0;
      if (state_q == ST_DIV) step_q <= step_q + 1'b1;
      else step_q <= '0;
      if (rsp_o.valid && rsp_o.ready) out_valid_q <= 1'b0;
      if ((state_q == ST_DIV_INIT && (den_q == '0 || num_q >= den_q)) ||
          (state_q == ST_DIV && step_q == StepW'(FracSteps - 1))) begin
        out_valid_q <= 1'b1;
      end
    end
  end

endmodule
